### hdl/scancode_to_ascii_line_input_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scancode line-input block
// Concurrent checks that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_LINE_INPUT_ASSERT_SVH
`define SCANCODE_TO_ASCII_LINE_INPUT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SC2ASC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sc2asc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SC2ASC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sc2asc assertion failed");

`else

`define SC2ASC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SC2ASC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/sc2asc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sc2asc_pkg
// Shared types, scancode constants and the US-layout key table.
// ---------------------------------------------------------------------------
package sc2asc_pkg;

    // Set 1 scancodes of interest
    localparam logic [7:0] RELEASE_BIT  = 8'h80;
    localparam logic [7:0] SC_BACKSPACE = 8'h0E;
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_CTRL      = 8'h1D;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_ALT       = 8'h38;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_L         = 8'h26;
    localparam logic [7:0] SC_F1        = 8'h3B;
    localparam logic [7:0] SC_F3        = 8'h3D;

    // Terminals and their index width
    localparam int NUM_TERMS = 3;
    localparam int TERM_W    = 2;

    // Output queue depth and pointer width
    localparam int Q_DEPTH = 3;
    localparam int Q_PTR_W = 2;

    // What the line state stage has to do with a request
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CONSUME,
        OP_BACKSPACE,
        OP_CHAR,
        OP_ENTER,
        OP_CLEAR
    } t_op_e;

    // Decoded request handed from the decoder to the line state stage
    typedef struct packed {
        t_op_e              op;
        logic               sw;
        logic [6:0]         ch;
        logic [TERM_W-1:0]  addr;
        logic [TERM_W-1:0]  shown;
    } t_request;

    // One result item; the last field sits in the lowest bits
    typedef struct packed {
        logic               line_ready;
        logic [6:0]         line_length;
        logic [TERM_W-1:0]  shown_now;
        logic               switch_request;
        logic               clear_request;
        logic               erase_request;
        logic [6:0]         store_position;
        logic               store_valid;
        logic [6:0]         echo_char;
        logic               echo_valid;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // Queue status seen by the top level
    typedef struct packed {
        logic [Q_PTR_W-1:0] count;
    } t_q_status;

    // Key table entry: display bit and the four variants
    typedef struct packed {
        logic       display;
        logic [6:0] plain;
        logic [6:0] caps;
        logic [6:0] shift;
        logic [6:0] caps_shift;
    } t_key_entry;

    // Symbol key: caps has no effect, shift picks the second character
    function automatic t_key_entry key_sym(input logic [7:0] base, input logic [7:0] shifted);
        t_key_entry e;
        e.display    = 1'b1;
        e.plain      = base[6:0];
        e.caps       = base[6:0];
        e.shift      = shifted[6:0];
        e.caps_shift = shifted[6:0];
        return e;
    endfunction

    // Letter key: caps and shift each flip the case, both together cancel
    function automatic t_key_entry key_let(input logic [7:0] lower);
        t_key_entry e;
        logic [7:0] upper;
        upper        = lower - 8'd32;
        e.display    = 1'b1;
        e.plain      = lower[6:0];
        e.caps       = upper[6:0];
        e.shift      = upper[6:0];
        e.caps_shift = lower[6:0];
        return e;
    endfunction

    // Fixed US-layout table indexed by the press code
    function automatic t_key_entry key_rom(input logic [6:0] code);
        t_key_entry e;
        e = '0;
        case (code)
            7'h02: e = key_sym("1", "!");
            7'h03: e = key_sym("2", "@");
            7'h04: e = key_sym("3", "#");
            7'h05: e = key_sym("4", "$");
            7'h06: e = key_sym("5", "%");
            7'h07: e = key_sym("6", "^");
            7'h08: e = key_sym("7", "&");
            7'h09: e = key_sym("8", "*");
            7'h0A: e = key_sym("9", "(");
            7'h0B: e = key_sym("0", ")");
            7'h0C: e = key_sym("-", "_");
            7'h0D: e = key_sym("=", "+");
            7'h0F: e = key_sym(8'h09, 8'h09);
            7'h10: e = key_let("q");
            7'h11: e = key_let("w");
            7'h12: e = key_let("e");
            7'h13: e = key_let("r");
            7'h14: e = key_let("t");
            7'h15: e = key_let("y");
            7'h16: e = key_let("u");
            7'h17: e = key_let("i");
            7'h18: e = key_let("o");
            7'h19: e = key_let("p");
            7'h1A: e = key_sym("[", "{");
            7'h1B: e = key_sym("]", "}");
            7'h1C: e = key_sym(8'h0A, 8'h0A);
            7'h1E: e = key_let("a");
            7'h1F: e = key_let("s");
            7'h20: e = key_let("d");
            7'h21: e = key_let("f");
            7'h22: e = key_let("g");
            7'h23: e = key_let("h");
            7'h24: e = key_let("j");
            7'h25: e = key_let("k");
            7'h26: e = key_let("l");
            7'h27: e = key_sym(";", ":");
            7'h28: e = key_sym(8'h27, 8'h22);
            7'h29: e = key_sym(8'h60, "~");
            7'h2B: e = key_sym(8'h5C, "|");
            7'h2C: e = key_let("z");
            7'h2D: e = key_let("x");
            7'h2E: e = key_let("c");
            7'h2F: e = key_let("v");
            7'h30: e = key_let("b");
            7'h31: e = key_let("n");
            7'h32: e = key_let("m");
            7'h33: e = key_sym(",", "<");
            7'h34: e = key_sym(".", ">");
            7'h35: e = key_sym("/", "?");
            7'h39: e = key_sym(" ", " ");
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

### hdl/sc2asc_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sc2asc_decode
// Modifier tracking, terminal selection and key table lookup for one request.
// ---------------------------------------------------------------------------
module sc2asc_decode
    import sc2asc_pkg::*;
#(
    parameter int KEY_COUNT = 70
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_kind,
    input  logic [7:0]         i_scancode,
    input  logic [TERM_W-1:0]  i_consumed_terminal,
    output t_request           o_req
);

    logic              r_shift, r_ctrl, r_alt, r_caps;
    logic              n_shift, n_ctrl, n_alt, n_caps;
    logic [TERM_W-1:0] r_shown, n_shown;
    t_key_entry        w_key;
    logic              w_in_bound;
    logic              w_fkey;
    logic [7:0]        w_fkey_off;

    // Table lookup and the key bound
    assign w_key      = key_rom(i_scancode[6:0]);
    assign w_in_bound = ({1'b0, i_scancode} < 9'(KEY_COUNT));
    assign w_fkey     = (i_scancode >= SC_F1) && (i_scancode <= SC_F3);
    assign w_fkey_off = i_scancode - SC_F1;

    // Request decode and next modifier state
    always_comb begin
        n_shift     = r_shift;
        n_ctrl      = r_ctrl;
        n_alt       = r_alt;
        n_caps      = r_caps;
        n_shown     = r_shown;
        o_req.op    = OP_NONE;
        o_req.sw    = 1'b0;
        o_req.ch    = '0;
        o_req.addr  = r_shown;
        if (i_kind) begin
            if (i_consumed_terminal < TERM_W'(NUM_TERMS)) begin
                o_req.op   = OP_CONSUME;
                o_req.addr = i_consumed_terminal;
            end
        end else if (i_scancode == SC_LSHIFT || i_scancode == SC_RSHIFT) begin
            n_shift = 1'b1;
        end else if (i_scancode == (SC_LSHIFT | RELEASE_BIT) ||
                     i_scancode == (SC_RSHIFT | RELEASE_BIT)) begin
            n_shift = 1'b0;
        end else if (i_scancode == SC_CTRL) begin
            n_ctrl = 1'b1;
        end else if (i_scancode == (SC_CTRL | RELEASE_BIT)) begin
            n_ctrl = 1'b0;
        end else if (i_scancode == SC_CAPS) begin
            n_caps = !r_caps;
        end else if (i_scancode == SC_ALT) begin
            n_alt = 1'b1;
        end else if (i_scancode == (SC_ALT | RELEASE_BIT)) begin
            n_alt = 1'b0;
        end else if (i_scancode == SC_BACKSPACE) begin
            o_req.op = OP_BACKSPACE;
        end else if (w_in_bound) begin
            if (r_ctrl && i_scancode == SC_L) begin
                o_req.op = OP_CLEAR;
            end else begin
                if (r_alt && w_fkey) begin
                    n_shown  = w_fkey_off[TERM_W-1:0];
                    o_req.sw = 1'b1;
                end
                if (w_key.display) begin
                    o_req.op = (i_scancode == SC_ENTER) ? OP_ENTER : OP_CHAR;
                    case ({r_shift, r_caps})
                        2'b00:   o_req.ch = w_key.plain;
                        2'b01:   o_req.ch = w_key.caps;
                        2'b10:   o_req.ch = w_key.shift;
                        default: o_req.ch = w_key.caps_shift;
                    endcase
                end
            end
        end
        o_req.shown = n_shown;
    end

    // Modifier and shown terminal registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
            r_alt   <= 1'b0;
            r_caps  <= 1'b0;
            r_shown <= '0;
        end else if (i_accept) begin
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
            r_alt   <= n_alt;
            r_caps  <= n_caps;
            r_shown <= n_shown;
        end
    end

endmodule

### hdl/sc2asc_line_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sc2asc_line_mem
// Per-terminal line count and newline flag in a small synchronous memory,
// updated by read-modify-write with forwarding of the last write.
// ---------------------------------------------------------------------------
module sc2asc_line_mem
    import sc2asc_pkg::*;
#(
    parameter int LINE_CAP = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_request  i_req,
    output logic      o_valid,
    output t_result   o_result
);

    localparam int CW = $clog2(LINE_CAP);
    localparam int EW = CW + 1;

    // Entry layout: newline flag above the count
    logic [EW-1:0]         r_mem [NUM_TERMS];
    logic [NUM_TERMS-1:0]  r_written;
    logic [EW-1:0]         r_rd_a, r_rd_b;
    logic                  r_s1_valid;
    t_request              r_s1_req;
    logic                  r_fw_en;
    logic [TERM_W-1:0]     r_fw_addr;
    logic [EW-1:0]         r_fw_data;

    logic [EW-1:0]         w_cur, w_shw, w_new;
    logic                  w_we;
    logic [CW-1:0]         w_cnt;
    logic                  w_room;
    logic [CW+6:0]         w_pos_ext, w_len_ext;
    logic [EW-1:0]         w_out_entry;

    // Read both ports on accept; entries never written read as empty
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_a <= r_written[i_req.addr]  ? r_mem[i_req.addr]  : '0;
            r_rd_b <= r_written[i_req.shown] ? r_mem[i_req.shown] : '0;
        end
    end

    // Stage register for the request whose read is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_req <= i_req;
        end
    end

    // Forward the write that landed at the same edge as the read
    assign w_cur = (r_fw_en && r_fw_addr == r_s1_req.addr)  ? r_fw_data : r_rd_a;
    assign w_shw = (r_fw_en && r_fw_addr == r_s1_req.shown) ? r_fw_data : r_rd_b;
    assign w_cnt  = w_cur[CW-1:0];
    assign w_room = (w_cnt < CW'(LINE_CAP - 1));

    // Modify step
    always_comb begin
        w_new    = w_cur;
        w_we     = 1'b0;
        o_result = '0;
        o_result.switch_request = r_s1_req.sw;
        o_result.shown_now      = r_s1_req.shown;
        case (r_s1_req.op)
            OP_CONSUME: begin
                w_new = '0;
                w_we  = r_s1_valid;
            end
            OP_BACKSPACE: begin
                if (w_cnt != '0) begin
                    w_new[CW-1:0]          = w_cnt - 1'b1;
                    w_we                   = r_s1_valid;
                    o_result.erase_request = 1'b1;
                end
            end
            OP_CHAR: begin
                if (w_room) begin
                    w_new[CW-1:0]           = w_cnt + 1'b1;
                    w_we                    = r_s1_valid;
                    o_result.echo_valid     = 1'b1;
                    o_result.echo_char      = r_s1_req.ch;
                    o_result.store_valid    = 1'b1;
                    o_result.store_position = w_pos_ext[6:0];
                end
            end
            OP_ENTER: begin
                w_new[CW] = 1'b1;
                w_we      = r_s1_valid;
                if (w_room) begin
                    o_result.echo_valid = 1'b1;
                    o_result.echo_char  = r_s1_req.ch;
                end
            end
            OP_CLEAR: begin
                o_result.clear_request = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        o_result.line_length = w_len_ext[6:0];
        o_result.line_ready  = w_out_entry[CW];
    end

    assign w_pos_ext   = (CW + 7)'(w_cnt);
    assign w_out_entry = (w_we && r_s1_req.shown == r_s1_req.addr) ? w_new : w_shw;
    assign w_len_ext   = (CW + 7)'(w_out_entry[CW-1:0]);
    assign o_valid     = r_s1_valid;

    // Write back
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_s1_req.addr] <= w_new;
        end
    end

    // Written marks and the forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_fw_en   <= 1'b0;
        end else begin
            r_fw_en <= w_we;
            if (w_we) begin
                r_written[r_s1_req.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= r_s1_req.addr;
        r_fw_data <= w_new;
    end

endmodule

### hdl/sc2asc_out_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sc2asc_out_queue
// Small result queue that decouples the pipeline from output stalls.
// ---------------------------------------------------------------------------
module sc2asc_out_queue
    import sc2asc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_data,
    output t_q_status  o_status
);

    t_result             r_slots [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_head, r_tail, r_count;
    logic [Q_PTR_W-1:0]  n_head, n_tail, n_count;
    logic                w_pop;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_slots[r_head];
    assign w_pop    = o_valid && i_ready;
    assign o_status.count = r_count;

    // Pointer and count update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_pop) begin
            n_head = (r_head == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_push) begin
            n_tail = (r_tail == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_tail] <= i_data;
        end
    end

endmodule

### hdl/scancode_to_ascii_line_input.sv
`timescale 1ns / 1ps
// An accepted request is registered into the line memory read stage, and its result
// is then written into the output queue. Throughput: one request per cycle while the
// output queue has room; the single read-modify-write pass over the per-terminal
// line memory sets this, and a three-entry output queue absorbs stalls.
// Reset clears modifiers, caps lock, the shown terminal and the memory's written
// marks, so every terminal reads as an empty line with no newline pending.
// ---------------------------------------------------------------------------
// scancode_to_ascii_line_input
// Set 1 scancode to ASCII decoder with line tracking for three terminals.
// ---------------------------------------------------------------------------
module scancode_to_ascii_line_input
    import sc2asc_pkg::*;
#(
    parameter int LINE_CAP  = 128,
    parameter int KEY_COUNT = 70
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // scancode[7:0], consumed_terminal[9:8]
    input  logic        i_s_axis_tuser,   // kind[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // echo_valid[0], echo_char[7:1], store_valid[8], store_position[15:9],
    // erase_request[16], clear_request[17], switch_request[18],
    // shown_now[20:19], line_length[27:21], line_ready[28]
    output logic [31:0] o_m_axis_tdata
);

`include "scancode_to_ascii_line_input_assert.svh"

    logic       w_accept;
    t_request   w_req;
    logic       w_s1_valid;
    t_result    w_s1_result;
    t_result    w_q_data;
    t_q_status  w_q_status;

    // Accept only while the queue can hold everything in flight
    assign o_s_axis_tready = ({1'b0, w_q_status.count} + (Q_PTR_W + 1)'(w_s1_valid))
                             < (Q_PTR_W + 1)'(Q_DEPTH);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    sc2asc_decode #(
        .KEY_COUNT (KEY_COUNT)
    ) u_decode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (w_accept),
        .i_kind              (i_s_axis_tuser),
        .i_scancode          (i_s_axis_tdata[7:0]),
        .i_consumed_terminal (i_s_axis_tdata[9:8]),
        .o_req               (w_req)
    );

    sc2asc_line_mem #(
        .LINE_CAP (LINE_CAP)
    ) u_line_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (w_req),
        .o_valid  (w_s1_valid),
        .o_result (w_s1_result)
    );

    sc2asc_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_s1_valid),
        .i_data   (w_s1_result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (w_q_data),
        .o_status (w_q_status)
    );

    assign o_m_axis_tdata = {(32 - RESULT_W)'(0), w_q_data};

    // Checks on pipeline occupancy and result consistency
    `SC2ASC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1,
        ({1'b0, w_q_status.count} + 3'(w_s1_valid)) <= 3'(Q_DEPTH))
    `SC2ASC_ASSERT_NXT(a_accept_reaches_stage, i_clk, i_rst_n, w_accept, w_s1_valid)
    `SC2ASC_ASSERT_IMP(a_store_has_echo, i_clk, i_rst_n,
        w_s1_valid && w_s1_result.store_valid, w_s1_result.echo_valid)
    `SC2ASC_ASSERT_IMP(a_erase_alone, i_clk, i_rst_n,
        w_s1_valid && w_s1_result.erase_request,
        !w_s1_result.echo_valid && !w_s1_result.store_valid)

endmodule

### test/scancode_to_ascii_line_input_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scancode_to_ascii_line_input_checker
// Watches both stream channels of the line-input decoder, predicts the result
// of every accepted request and compares each accepted result field by field.
// ---------------------------------------------------------------------------
module scancode_to_ascii_line_input_checker
    import sc2asc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // scancode[7:0], consumed_terminal[9:8]
    input  logic        i_s_tuser,   // kind[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // echo_valid[0] up to line_ready[28]
    output int          o_errors,
    output int          o_pending
);

    localparam int LINE_LIMIT = 128;
    localparam int KEY_BOUND  = 70;

    // US layout, one byte per press code; '?' in the plain row marks a key
    // that shows nothing.
    localparam logic [8*KEY_BOUND-1:0] PLAIN_KEYS = {
        "??1234567890-=?", 8'h09, "qwertyuiop[]", 8'h0A, "?asdfghjkl;",
        8'h27, 8'h60, "?", 8'h5C, "zxcvbnm,./??? ????????????"
    };
    localparam logic [8*KEY_BOUND-1:0] SHIFT_KEYS = {
        "??!@#$%^&*()_+?", 8'h09, "QWERTYUIOP{}", 8'h0A, "?ASDFGHJKL:",
        8'h22, "~?|ZXCVBNM<>???? ????????????"
    };

    // Model of the decoder state
    logic       shift_on;
    logic       ctrl_on;
    logic       alt_on;
    logic       caps_on;
    logic [1:0] shown_term;
    int         line_chars [NUM_TERMS];
    logic       line_done  [NUM_TERMS];

    t_result    keystroke_results_q [$];
    int         error_count = 0;

    // Character of one key: bit 7 says the key shows something.
    function automatic logic [7:0] key_glyph(input int code, input logic shift,
                                             input logic caps);
        logic [7:0] plain;
        logic [7:0] shifted;
        plain   = PLAIN_KEYS[8*(KEY_BOUND-1-code) +: 8];
        shifted = SHIFT_KEYS[8*(KEY_BOUND-1-code) +: 8];
        if (plain == "?") begin
            return 8'h00;
        end
        // Letters flip case on shift or caps, both together cancel.
        if (plain >= "a" && plain <= "z") begin
            return {1'b1, (shift ^ caps) ? 7'(plain - 8'd32) : plain[6:0]};
        end
        return {1'b1, shift ? shifted[6:0] : plain[6:0]};
    endfunction

    // Next decoder state and the result caused by one request
    function automatic t_result predict_keystroke(input logic kind, input logic [7:0] code,
                                                  input logic [1:0] term);
        t_result    r;
        logic [1:0] t;
        logic [7:0] key;
        r = '0;
        t = shown_term;
        if (kind) begin
            if (term < NUM_TERMS) begin
                line_chars[term] = 0;
                line_done[term]  = 1'b0;
            end
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_on = 1'b1;
        end else if (code == (SC_LSHIFT | RELEASE_BIT) || code == (SC_RSHIFT | RELEASE_BIT)) begin
            shift_on = 1'b0;
        end else if (code == SC_CTRL) begin
            ctrl_on = 1'b1;
        end else if (code == (SC_CTRL | RELEASE_BIT)) begin
            ctrl_on = 1'b0;
        end else if (code == SC_CAPS) begin
            caps_on = ~caps_on;
        end else if (code == SC_ALT) begin
            alt_on = 1'b1;
        end else if (code == (SC_ALT | RELEASE_BIT)) begin
            alt_on = 1'b0;
        end else if (code == SC_BACKSPACE) begin
            if (line_chars[t] != 0) begin
                line_chars[t]   = line_chars[t] - 1;
                r.erase_request = 1'b1;
            end
        end else if (code < KEY_BOUND) begin
            if (ctrl_on && code == SC_L) begin
                r.clear_request = 1'b1;
            end else begin
                if (alt_on && code >= SC_F1 && code <= SC_F3) begin
                    shown_term       = 2'(code - SC_F1);
                    r.switch_request = 1'b1;
                end
                key = key_glyph(int'(code), shift_on, caps_on);
                if (key[7]) begin
                    // A full line drops the character; enter still marks the line.
                    if (line_chars[t] < LINE_LIMIT - 1) begin
                        if (code != SC_ENTER) begin
                            r.store_valid    = 1'b1;
                            r.store_position = 7'(line_chars[t]);
                            line_chars[t]    = line_chars[t] + 1;
                        end
                        r.echo_valid = 1'b1;
                        r.echo_char  = key[6:0];
                    end
                    if (code == SC_ENTER) begin
                        line_done[t] = 1'b1;
                    end
                end
            end
        end
        r.shown_now   = shown_term;
        r.line_length = 7'(line_chars[shown_term]);
        r.line_ready  = line_done[shown_term];
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count = error_count + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare accepted results first, then record the request accepted at this edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            shift_on   = 1'b0;
            ctrl_on    = 1'b0;
            alt_on     = 1'b0;
            caps_on    = 1'b0;
            shown_term = '0;
            for (int i = 0; i < NUM_TERMS; i++) begin
                line_chars[i] = 0;
                line_done[i]  = 1'b0;
            end
            keystroke_results_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[RESULT_W-1:0]);
                if (keystroke_results_q.size() == 0) begin
                    error_count = error_count + 1;
                    $display("%0t: result with none expected, expected nothing, actual %0h",
                             $time, got);
                end else begin
                    want = keystroke_results_q.pop_front();
                    check_field("echo_valid", want.echo_valid, got.echo_valid);
                    check_field("echo_char", want.echo_char, got.echo_char);
                    check_field("store_valid", want.store_valid, got.store_valid);
                    check_field("store_position", want.store_position, got.store_position);
                    check_field("erase_request", want.erase_request, got.erase_request);
                    check_field("clear_request", want.clear_request, got.clear_request);
                    check_field("switch_request", want.switch_request, got.switch_request);
                    check_field("shown_now", want.shown_now, got.shown_now);
                    check_field("line_length", want.line_length, got.line_length);
                    check_field("line_ready", want.line_ready, got.line_ready);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                keystroke_results_q.push_back(
                    predict_keystroke(i_s_tuser, i_s_tdata[7:0], i_s_tdata[9:8]));
            end
        end
        o_pending <= keystroke_results_q.size();
        o_errors  <= error_count;
    end

endmodule

### test/tb_scancode_to_ascii_line_input.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_scancode_to_ascii_line_input
// Feeds the line-input decoder with directed key sequences, then with random
// typing, fill bursts, line consumes and noise under changing stall patterns.
// ---------------------------------------------------------------------------
module tb_scancode_to_ascii_line_input;
    import sc2asc_pkg::*;

    localparam int ITEM_TARGET = 1850;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    int          errors;
    int          pending;
    int          tx_idle_pct = 12;
    int          rx_idle_pct = 50;
    int          typed_items = 0;

    scancode_to_ascii_line_input i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    scancode_to_ascii_line_input_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stalls at random.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one request, idling at random first, and return once it is taken.
    task automatic send_item(input logic kind, input logic [7:0] code, input logic [1:0] term);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, term, code};
        do begin
            @(posedge clk);
        end while (!s_tready);
    endtask

    task automatic press_key(input logic [7:0] code);
        send_item(1'b0, code, 2'($urandom_range(3)));
        typed_items = typed_items + 1;
    endtask

    task automatic consume_line(input logic [1:0] term);
        send_item(1'b1, 8'($urandom_range(255)), term);
        typed_items = typed_items + 1;
    endtask

    // Hold off new requests until every result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
    endtask

    // Ordinary typing with modifiers, function keys, edits and consumes mixed in.
    task automatic typing_run(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 58) begin
                press_key(8'($urandom_range(8'h39, 8'h02)));
            end else if (roll < 66) begin
                press_key(SC_ENTER);
            end else if (roll < 74) begin
                press_key(SC_BACKSPACE);
            end else if (roll < 88) begin
                case ($urandom_range(7))
                    0: press_key(SC_LSHIFT);
                    1: press_key(SC_RSHIFT);
                    2: press_key(8'($urandom_range(1)) ? (SC_LSHIFT | RELEASE_BIT)
                                                        : (SC_RSHIFT | RELEASE_BIT));
                    3: press_key(SC_CTRL);
                    4: press_key(SC_CTRL | RELEASE_BIT);
                    5: press_key(SC_ALT);
                    6: press_key(SC_ALT | RELEASE_BIT);
                    default: press_key(SC_CAPS);
                endcase
            end else if (roll < 93) begin
                press_key(8'(SC_F1 + $urandom_range(2)));
            end else if (roll < 96) begin
                press_key(SC_L);
            end else begin
                consume_line(2'($urandom_range(3)));
            end
        end
    endtask

    // Fill the shown line past its capacity, then work around the full mark.
    task automatic fill_burst();
        press_key(SC_CTRL | RELEASE_BIT);
        repeat ($urandom_range(140, 126)) press_key(8'($urandom_range(8'h19, 8'h10)));
        press_key(SC_BACKSPACE);
        repeat ($urandom_range(3, 1)) press_key(8'($urandom_range(8'h35, 8'h2C)));
        press_key(SC_ENTER);
    endtask

    // Raw bytes of any value.
    task automatic noise_run(input int count);
        for (int i = 0; i < count; i++) begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                      2'($urandom_range(3)));
            typed_items = typed_items + 1;
        end
    endtask

    initial begin
        int roll;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence: plain, shift, caps, both, enter, edits and consumes.
        press_key(8'h10);
        press_key(SC_LSHIFT);
        press_key(8'h10);
        press_key(8'h0B);
        press_key(SC_LSHIFT | RELEASE_BIT);
        press_key(SC_CAPS);
        press_key(8'h1E);
        press_key(SC_RSHIFT);
        press_key(8'h1E);
        press_key(SC_RSHIFT | RELEASE_BIT);
        press_key(SC_CAPS);
        press_key(SC_ENTER);
        press_key(SC_BACKSPACE);
        consume_line(2'd0);
        press_key(SC_BACKSPACE);
        // Ctrl+L clears, ctrl with a digit still types it.
        press_key(SC_CTRL);
        press_key(SC_L);
        press_key(8'h02);
        press_key(SC_CTRL | RELEASE_BIT);
        // Alt with each function key switches the shown terminal.
        press_key(SC_ALT);
        press_key(8'(SC_F1 + 1));
        press_key(SC_F3);
        press_key(SC_F1);
        press_key(SC_ALT | RELEASE_BIT);
        // Escape prefix, release of nothing, key bound edges, terminal three.
        press_key(8'hE0);
        press_key(8'hFF);
        press_key(8'(70));
        press_key(8'(69));
        consume_line(2'd3);
        wait_drained();

        // Random part in three stall patterns.
        while (typed_items < ITEM_TARGET) begin
            if (typed_items >= (2 * ITEM_TARGET) / 3 && tx_idle_pct != 0) begin
                wait_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (typed_items >= ITEM_TARGET / 3 && tx_idle_pct == 12) begin
                wait_drained();
                tx_idle_pct = 50;
                rx_idle_pct = 12;
            end
            roll = $urandom_range(99);
            if (roll < 62) begin
                typing_run($urandom_range(40, 10));
            end else if (roll < 70) begin
                fill_burst();
            end else if (roll < 82) begin
                consume_line(2'd0);
                consume_line(2'd1);
                consume_line(2'd2);
            end else begin
                noise_run($urandom_range(15, 5));
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("PASS scancode_to_ascii_line_input");
        end else begin
            $display("FAIL scancode_to_ascii_line_input");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAIL scancode_to_ascii_line_input");
        $finish;
    end

endmodule
